FILE: rtl/core/alu8_pkg.sv
// alu8_pkg: operation codes and transaction payload types for the 8-bit alu
// no dependencies; imported by alu8_exec and cpu8_alu_with_flags_core
package alu8_pkg;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBB = 4'd3,
		OP_AND = 4'd4,
		OP_XOR = 4'd5,
		OP_OR  = 4'd6,
		OP_CMP = 4'd7,
		OP_INR = 4'd8,
		OP_DCR = 4'd9,
		OP_RLC = 4'd10,
		OP_RRC = 4'd11,
		OP_RAL = 4'd12,
		OP_RAR = 4'd13,
		OP_DAA = 4'd14,
		OP_DAD = 4'd15
	} alu_op_t;

	localparam logic [3:0] DAA_LIMIT   = 4'd9;
	localparam logic [8:0] DAA_ADJ_LO  = 9'h006;
	localparam logic [8:0] DAA_ADJ_HI  = 9'h060;
	localparam logic [4:0] DAA_LIMIT_H = 5'd9;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [7:0]  acc_in;
		logic        carry_in;
		logic        zero_in;
		logic        sign_in;
		logic        parity_in;
		logic [7:0]  operand;
		logic [15:0] pair_operand;
		logic [15:0] hl_in;
	} alu_req_t;

	typedef struct packed {
		logic [7:0]  acc_out;
		logic [7:0]  reg_out;
		logic [15:0] hl_out;
		logic        zero_out;
		logic        sign_out;
		logic        parity_out;
		logic        carry_out;
	} alu_rsp_t;

endpackage

FILE: rtl/core/cpu8_alu_with_flags_core.sv
// cpu8_alu_with_flags_core: top level of the 8-bit alu with flags
// depends on alu8_pkg and alu8_exec
//
// One operation in, one result out. A transaction accepted on req is
// captured in an input register, goes through the combinational alu
// datapath and is loaded into the result register when that register is
// free or emptying; the result then shows on rsp. Both registers hold one
// transaction each and move independently, so one operation is accepted
// every cycle as long as rsp_ready keeps up; req_ready only drops when both
// registers are full and rsp_ready is low. Flags an operation does not touch
// pass through from the request; auxiliary carry is not provided.
module cpu8_alu_with_flags_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  alu8_pkg::alu_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output alu8_pkg::alu_rsp_t rsp
);
	import alu8_pkg::*;

	alu_req_t req_s1;
	logic     valid_s1;
	alu_rsp_t rsp_s2;
	logic     valid_s2;
	alu_rsp_t exec_rsp;
	logic     load_s2;
	logic     load_s1;

	assign load_s2   = ~valid_s2 | rsp_ready;
	assign req_ready = ~valid_s1 | load_s2;
	assign load_s1   = req_valid & req_ready;

	alu8_exec u_exec (
		.req (req_s1),
		.rsp (exec_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= req;
		end
		if (load_s2 && valid_s1) begin
			rsp_s2 <= exec_rsp;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

`ifndef SYNTHESIS
	// a captured operation reaches the result register when it can move
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 |=> rsp_valid)
		else $error("operation lost between input and result register");

	// a taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !valid_s1 |=> !rsp_valid)
		else $error("result repeated after transaction");

	// back-pressure only when both registers are occupied
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && rsp_valid && !rsp_ready)
		else $error("req_ready low with free register");

	// a stalled input register keeps its operation
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(req_s1))
		else $error("stalled operation changed");
`endif

endmodule

FILE: rtl/core/alu8_exec.sv
// alu8_exec: single-pass datapath of the alu, one operation to one result
// depends on alu8_pkg for the op codes and payload structs
module alu8_exec (
	input  alu8_pkg::alu_req_t req,
	output alu8_pkg::alu_rsp_t rsp
);
	import alu8_pkg::*;

	alu_op_t     op;
	logic [8:0]  add_sum;
	logic [8:0]  sub_amt;
	logic [9:0]  sub_diff;
	logic [16:0] dad_sum;
	logic [8:0]  daa_lo;
	logic        daa_hi;
	logic [8:0]  daa_res;
	logic [7:0]  res;
	logic        set_zsp;

	assign op = alu_op_t'(req.req_type);

	always_comb begin
		add_sum  = {1'b0, req.acc_in} + {1'b0, req.operand}
			+ {8'd0, (op == OP_ADC) & req.carry_in};
		sub_amt  = {1'b0, req.operand} + {8'd0, (op == OP_SBB) & req.carry_in};
		sub_diff = {2'b00, req.acc_in} - {1'b0, sub_amt};
		dad_sum  = {1'b0, req.hl_in} + {1'b0, req.pair_operand};
		// decimal adjust: low nibble first, then high on the 9-bit intermediate
		daa_lo   = (req.acc_in[3:0] > DAA_LIMIT) ? {1'b0, req.acc_in} + DAA_ADJ_LO
			: {1'b0, req.acc_in};
		daa_hi   = (daa_lo[8:4] > DAA_LIMIT_H) || req.carry_in;
		daa_res  = daa_hi ? daa_lo + DAA_ADJ_HI : daa_lo;
	end

	always_comb begin
		rsp.acc_out    = req.acc_in;
		rsp.reg_out    = req.operand;
		rsp.hl_out     = req.hl_in;
		rsp.carry_out  = req.carry_in;
		res            = 8'd0;
		set_zsp        = 1'b1;
		case (op)
			OP_ADD, OP_ADC: begin
				res           = add_sum[7:0];
				rsp.acc_out   = res;
				rsp.carry_out = add_sum[8];
			end
			OP_SUB, OP_SBB, OP_CMP: begin
				res           = sub_diff[7:0];
				rsp.carry_out = sub_diff[9];
				if (op != OP_CMP) begin
					rsp.acc_out = res;
				end
			end
			OP_AND: begin
				res           = req.acc_in & req.operand;
				rsp.acc_out   = res;
				rsp.carry_out = 1'b0;
			end
			OP_XOR: begin
				res           = req.acc_in ^ req.operand;
				rsp.acc_out   = res;
				rsp.carry_out = 1'b0;
			end
			OP_OR: begin
				res           = req.acc_in | req.operand;
				rsp.acc_out   = res;
				rsp.carry_out = 1'b0;
			end
			OP_INR: begin
				res         = req.operand + 8'd1;
				rsp.reg_out = res;
			end
			OP_DCR: begin
				res         = req.operand - 8'd1;
				rsp.reg_out = res;
			end
			OP_RLC: begin
				rsp.acc_out   = {req.acc_in[6:0], req.acc_in[7]};
				rsp.carry_out = req.acc_in[7];
				set_zsp       = 1'b0;
			end
			OP_RRC: begin
				rsp.acc_out   = {req.acc_in[0], req.acc_in[7:1]};
				rsp.carry_out = req.acc_in[0];
				set_zsp       = 1'b0;
			end
			OP_RAL: begin
				rsp.acc_out   = {req.acc_in[6:0], req.carry_in};
				rsp.carry_out = req.acc_in[7];
				set_zsp       = 1'b0;
			end
			OP_RAR: begin
				rsp.acc_out   = {req.carry_in, req.acc_in[7:1]};
				rsp.carry_out = req.acc_in[0];
				set_zsp       = 1'b0;
			end
			OP_DAA: begin
				res           = daa_res[7:0];
				rsp.acc_out   = res;
				rsp.carry_out = daa_hi;
			end
			OP_DAD: begin
				rsp.hl_out    = dad_sum[15:0];
				rsp.carry_out = dad_sum[16];
				set_zsp       = 1'b0;
			end
			default: begin
				set_zsp = 1'b0;
			end
		endcase

		if (set_zsp) begin
			rsp.zero_out   = (res == 8'd0);
			rsp.sign_out   = res[7];
			rsp.parity_out = ~^res;
		end else begin
			rsp.zero_out   = req.zero_in;
			rsp.sign_out   = req.sign_in;
			rsp.parity_out = req.parity_in;
		end
	end

endmodule

FILE: tb/sv/alu8_flag_checker.sv
`timescale 1ns / 100ps
// alu8_flag_checker: watches the req and rsp channels of the 8-bit alu, works out the
// result of every accepted operation and compares it with what comes back; uses alu8_pkg
module alu8_flag_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  alu8_pkg::alu_req_t req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  alu8_pkg::alu_rsp_t rsp,
	output int                 mismatch_count,
	output int                 outstanding
);
	import alu8_pkg::*;

	alu_rsp_t awaited_rsp_q[$];
	int       errs;

	function automatic alu_rsp_t alu_outcome(alu_req_t r);
		alu_rsp_t    o;
		alu_op_t     op;
		logic [8:0]  wide;
		logic [8:0]  subtrahend;
		logic [16:0] wide16;
		logic [7:0]  res;
		logic        cy;
		logic        hi;
		logic        flag_res;
		op = alu_op_t'(r.req_type);
		o.acc_out = r.acc_in;
		o.reg_out = r.operand;
		o.hl_out = r.hl_in;
		o.zero_out = r.zero_in;
		o.sign_out = r.sign_in;
		o.parity_out = r.parity_in;
		cy = r.carry_in;
		res = '0;
		flag_res = 1'b1;
		case (op)
			OP_ADD, OP_ADC: begin
				wide = {1'b0, r.acc_in} + {1'b0, r.operand};
				if (op == OP_ADC)
					wide = wide + {8'd0, r.carry_in};
				res = wide[7:0];
				o.acc_out = res;
				cy = wide[8];
			end
			OP_SUB, OP_SBB, OP_CMP: begin
				subtrahend = {1'b0, r.operand};
				if (op == OP_SBB)
					subtrahend = subtrahend + {8'd0, r.carry_in};
				wide = {1'b0, r.acc_in} - subtrahend;
				res = wide[7:0];
				cy = ({1'b0, r.acc_in} < subtrahend);
				if (op != OP_CMP)
					o.acc_out = res;
			end
			OP_AND: begin
				res = r.acc_in & r.operand;
				o.acc_out = res;
				cy = 1'b0;
			end
			OP_XOR: begin
				res = r.acc_in ^ r.operand;
				o.acc_out = res;
				cy = 1'b0;
			end
			OP_OR: begin
				res = r.acc_in | r.operand;
				o.acc_out = res;
				cy = 1'b0;
			end
			OP_INR: begin
				res = r.operand + 8'd1;
				o.reg_out = res;
			end
			OP_DCR: begin
				res = r.operand - 8'd1;
				o.reg_out = res;
			end
			OP_RLC: begin
				cy = r.acc_in[7];
				o.acc_out = {r.acc_in[6:0], r.acc_in[7]};
				flag_res = 1'b0;
			end
			OP_RRC: begin
				cy = r.acc_in[0];
				o.acc_out = {r.acc_in[0], r.acc_in[7:1]};
				flag_res = 1'b0;
			end
			OP_RAL: begin
				o.acc_out = {r.acc_in[6:0], r.carry_in};
				cy = r.acc_in[7];
				flag_res = 1'b0;
			end
			OP_RAR: begin
				o.acc_out = {r.carry_in, r.acc_in[7:1]};
				cy = r.acc_in[0];
				flag_res = 1'b0;
			end
			OP_DAA: begin
				wide = {1'b0, r.acc_in};
				if (r.acc_in[3:0] > DAA_LIMIT)
					wide = wide + DAA_ADJ_LO;
				// high adjust looks at the intermediate, a set carry forces it
				hi = (wide[8:4] > DAA_LIMIT_H) || r.carry_in;
				if (hi)
					wide = wide + DAA_ADJ_HI;
				cy = hi;
				res = wide[7:0];
				o.acc_out = res;
			end
			default: begin
				wide16 = {1'b0, r.hl_in} + {1'b0, r.pair_operand};
				cy = wide16[16];
				o.hl_out = wide16[15:0];
				flag_res = 1'b0;
			end
		endcase
		if (flag_res) begin
			o.zero_out = (res == 8'd0);
			o.sign_out = res[7];
			o.parity_out = ~^res;
		end
		o.carry_out = cy;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_rsp_t want;
		if (!arst_n) begin
			awaited_rsp_q.delete();
			errs = 0;
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			// retire first: a result can never belong to the request taken this edge
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected result: acc %02h reg %02h hl %04h zspc %b%b%b%b",
							rsp.acc_out, rsp.reg_out, rsp.hl_out, rsp.zero_out,
							rsp.sign_out, rsp.parity_out, rsp.carry_out);
				end else begin
					want = awaited_rsp_q.pop_front();
					if (rsp.acc_out !== want.acc_out || rsp.reg_out !== want.reg_out ||
						rsp.hl_out !== want.hl_out || rsp.zero_out !== want.zero_out ||
						rsp.sign_out !== want.sign_out || rsp.parity_out !== want.parity_out ||
						rsp.carry_out !== want.carry_out) begin
						errs++;
						if (errs <= 10) begin
							$display("mismatch: exp acc %02h reg %02h hl %04h zspc %b%b%b%b",
								want.acc_out, want.reg_out, want.hl_out, want.zero_out,
								want.sign_out, want.parity_out, want.carry_out);
							$display("          got acc %02h reg %02h hl %04h zspc %b%b%b%b",
								rsp.acc_out, rsp.reg_out, rsp.hl_out, rsp.zero_out,
								rsp.sign_out, rsp.parity_out, rsp.carry_out);
						end
					end
				end
			end
			if (req_valid && req_ready)
				awaited_rsp_q.push_back(alu_outcome(req));
			mismatch_count <= errs;
			outstanding <= awaited_rsp_q.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for cpu8_alu_with_flags_core
// depends on alu8_pkg, the core and alu8_flag_checker
module tb;
	import alu8_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	alu_req_t req;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	alu_rsp_t rsp;
	int       send_idle;
	int       recv_idle;
	int       mismatch_count;
	int       outstanding;
	int       quiet_cycles = 0;

	cpu8_alu_with_flags_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	alu8_flag_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle);
	end

	// cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			4: return {4'($urandom_range(9)), 4'($urandom_range(9))};
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic alu_req_t random_op();
		alu_req_t r;
		r.req_type = 4'($urandom_range(15));
		r.acc_in = pick_byte();
		r.operand = pick_byte();
		r.carry_in = 1'($urandom_range(1));
		r.zero_in = 1'($urandom_range(1));
		r.sign_in = 1'($urandom_range(1));
		r.parity_in = 1'($urandom_range(1));
		r.pair_operand = pick_word();
		r.hl_in = pick_word();
		return r;
	endfunction

	function automatic alu_req_t make_op(alu_op_t op, logic [7:0] a, logic [7:0] x,
		logic [3:0] czsp, logic [15:0] pair, logic [15:0] hl);
		alu_req_t r;
		r.req_type = op;
		r.acc_in = a;
		r.operand = x;
		{r.carry_in, r.zero_in, r.sign_in, r.parity_in} = czsp;
		r.pair_operand = pair;
		r.hl_in = hl;
		return r;
	endfunction

	task automatic send_op(input alu_req_t item);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// hold the request side until every result is back
	task automatic wait_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		send_idle <= 29;
		recv_idle <= 62;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(make_op(OP_ADD, 8'hff, 8'h01, 4'b0000, 16'h0000, 16'h0000));
		send_op(make_op(OP_ADD, 8'h7f, 8'h01, 4'b1111, 16'hffff, 16'hffff));
		send_op(make_op(OP_ADC, 8'hff, 8'hff, 4'b1000, 16'h0000, 16'hffff));
		send_op(make_op(OP_ADC, 8'h00, 8'h00, 4'b1111, 16'hffff, 16'h0000));
		send_op(make_op(OP_SUB, 8'h00, 8'h01, 4'b0000, 16'h0000, 16'h0000));
		send_op(make_op(OP_SUB, 8'h55, 8'h55, 4'b1000, 16'h0000, 16'h0000));
		// borrow in on top of 0xff gives a subtrahend past eight bits
		send_op(make_op(OP_SBB, 8'h00, 8'hff, 4'b1000, 16'h0000, 16'h0000));
		send_op(make_op(OP_SBB, 8'h80, 8'h7f, 4'b1111, 16'h0000, 16'h0000));
		send_op(make_op(OP_AND, 8'hff, 8'h00, 4'b1000, 16'h0000, 16'h0000));
		send_op(make_op(OP_XOR, 8'haa, 8'h55, 4'b1111, 16'h0000, 16'h0000));
		send_op(make_op(OP_OR, 8'h00, 8'h00, 4'b1000, 16'h0000, 16'h0000));
		send_op(make_op(OP_CMP, 8'h10, 8'h10, 4'b0000, 16'h0000, 16'h0000));
		send_op(make_op(OP_CMP, 8'h00, 8'hff, 4'b0111, 16'h0000, 16'h0000));
		send_op(make_op(OP_INR, 8'h33, 8'hff, 4'b1000, 16'h0000, 16'h0000));
		send_op(make_op(OP_DCR, 8'h33, 8'h00, 4'b0111, 16'h0000, 16'h0000));
		send_op(make_op(OP_RLC, 8'h80, 8'h00, 4'b0111, 16'h0000, 16'h0000));
		send_op(make_op(OP_RRC, 8'h01, 8'h00, 4'b0000, 16'h0000, 16'h0000));
		send_op(make_op(OP_RAL, 8'h80, 8'h00, 4'b0101, 16'h0000, 16'h0000));
		send_op(make_op(OP_RAR, 8'h01, 8'h00, 4'b1010, 16'h0000, 16'h0000));
		// low nibble over nine, and the high adjust that follows from it
		send_op(make_op(OP_DAA, 8'h9b, 8'h00, 4'b0000, 16'h0000, 16'h0000));
		// a set carry forces the high adjust even when the high nibble is nine or less
		send_op(make_op(OP_DAA, 8'h15, 8'h00, 4'b1000, 16'h0000, 16'h0000));
		send_op(make_op(OP_DAA, 8'h99, 8'h00, 4'b0111, 16'h0000, 16'h0000));
		send_op(make_op(OP_DAA, 8'h0a, 8'h00, 4'b0000, 16'h0000, 16'h0000));
		send_op(make_op(OP_DAD, 8'h00, 8'h00, 4'b0111, 16'h0001, 16'hffff));
		send_op(make_op(OP_DAD, 8'hff, 8'hff, 4'b1000, 16'h4321, 16'h1234));

		for (int i = 0; i < 580; i++)
			send_op(random_op());
		wait_results();

		send_idle <= 62;
		recv_idle <= 29;
		for (int i = 0; i < 580; i++)
			send_op(random_op());
		wait_results();

		send_idle <= 0;
		recv_idle <= 0;
		for (int i = 0; i < 590; i++) begin
			if (i == 300)
				wait_results();
			send_op(random_op());
		end
		wait_results();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: cpu8_alu_with_flags_core.f
rtl/core/alu8_pkg.sv
rtl/core/alu8_exec.sv
rtl/core/cpu8_alu_with_flags_core.sv
tb/sv/alu8_flag_checker.sv
tb/sv/tb.sv
